[rtl/core/vector_clock_race_detector_defines.svh]
// Assertion macros used by the race detector top module.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
`ifndef VECTOR_CLOCK_RACE_DETECTOR_DEFINES_SVH
`define VECTOR_CLOCK_RACE_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is active
`define VCRD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active
`define VCRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define VCRD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define VCRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

[rtl/core/vcrd_pkg.sv]
package vcrd_pkg;

    // Action codes carried in the input word
    localparam logic [2:0] ACT_START   = 3'd0;
    localparam logic [2:0] ACT_FORK    = 3'd1;
    localparam logic [2:0] ACT_JOIN    = 3'd2;
    localparam logic [2:0] ACT_ACQUIRE = 3'd3;
    localparam logic [2:0] ACT_RELEASE = 3'd4;
    localparam logic [2:0] ACT_ACCESS  = 3'd5;

    // Widest thread and lock indexes any configuration uses
    localparam int THR_IDX_W   = 6;
    localparam int LOCK_IDX_W  = 8;
    localparam int ADDR_W      = 48;
    localparam int WORD_ADDR_W = 45;
    localparam int KEY_W       = 46;

    localparam logic [63:0] HASH_MUL = 64'h9E3779B97F4A7C15;

    typedef struct packed {
        logic [2:0]        action;
        logic [2:0]        thread_id;
        logic [2:0]        other_thread_id;
        logic [3:0]        lock_id;
        logic [ADDR_W-1:0] address;
        logic              wr_access;
    } t_in_word;

    typedef struct packed {
        logic       race;
        logic [3:0] new_thread_id;
        logic       table_full;
        logic       rejected;
    } t_out_word;

    // Element operation of a vector clock walk
    typedef enum logic [1:0] {
        VC_ZERO,
        VC_COPY,
        VC_MAX
    } t_vc_op;

    typedef struct packed {
        logic                  go;
        t_vc_op                op;
        logic                  src_lock;
        logic                  dst_lock;
        logic [THR_IDX_W-1:0]  src_row;
        logic [THR_IDX_W-1:0]  dst_row;
        logic [LOCK_IDX_W-1:0] lock_row;
        logic                  tick_en;
        logic [THR_IDX_W-1:0]  tick_idx;
        logic                  post_tick;
        logic [THR_IDX_W-1:0]  post_row;
    } t_vc_cmd;

    typedef struct packed {
        logic [THR_IDX_W-1:0] row;
        logic [THR_IDX_W-1:0] col;
    } t_vc_look;

    typedef struct packed {
        logic ready;
        logic done;
    } t_vc_stat;

    typedef struct packed {
        logic                 go;
        logic [THR_IDX_W-1:0] thread_id;
        logic [ADDR_W-1:0]    address;
        logic                 wr_access;
    } t_sh_cmd;

    typedef struct packed {
        logic ready;
        logic done;
        logic race;
        logic full;
    } t_sh_stat;

endpackage

[rtl/core/vector_clock_race_detector.sv]
// Happens-before race detector. Drive a word with start while busy is low; the
// result comes back on o_word with o_done high for one cycle and cannot be
// stalled. A rejected word is answered straight from the idle state. Start,
// join and acquire walk the thread clock one entry per cycle; fork and
// release add a trailing tick of the thread's own entry. An access runs the
// probe loop on the key memory and the per-cell lookup in the thread clock
// memory. After reset, busy stays high during a clearing pass of the bucket
// memories and of the lock memory, which holds 2**ceil(log2 LOCKS) *
// 2**ceil(log2 THREADS) entries.
`include "vector_clock_race_detector_defines.svh"

module vector_clock_race_detector import vcrd_pkg::*; #(
    parameter int THREADS    = 8,
    parameter int CELLS      = 4,
    parameter int BUCKETS    = 1024,
    parameter int LOCKS      = 16,
    parameter int EPOCH_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_word  i_word,
    output logic      busy,
    output logic      o_done,
    output t_out_word o_word
);

    localparam int TW = $clog2(THREADS);
    localparam int NW = TW + 1;
    localparam logic [3:0] NONE_ID = 4'(THREADS);

    typedef enum logic [1:0] {
        T_IDLE,
        T_VC,
        T_SH
    } t_state;

    t_state        r_state;
    logic [NW-1:0] r_next;
    logic [3:0]    r_newid;
    t_vc_cmd       r_vc_cmd;
    t_sh_cmd       r_sh_cmd;

    t_vc_stat              vc_stat;
    t_sh_stat              sh_stat;
    t_vc_look              look;
    logic [EPOCH_BITS-1:0] look_epoch;

    logic     accept;
    logic     alloc_t;
    logic     alloc_o;
    logic     lock_ok;
    logic     ids_full;
    logic     dec_rej;
    logic     dec_bump;
    t_vc_cmd  dec_vc;
    t_sh_cmd  dec_sh;

    assign busy   = (r_state != T_IDLE) || !(vc_stat.ready && sh_stat.ready);
    assign accept = start && !busy;

    assign alloc_t  = 8'(i_word.thread_id) < 8'(r_next);
    assign alloc_o  = 8'(i_word.other_thread_id) < 8'(r_next);
    assign lock_ok  = 9'(i_word.lock_id) < 9'(LOCKS);
    assign ids_full = (r_next == NW'(THREADS));

    // Decode the incoming word into a clock walk or a shadow access
    always_comb begin
        dec_rej  = 1'b0;
        dec_bump = 1'b0;
        dec_vc   = '0;
        dec_sh   = '0;
        dec_vc.lock_row = LOCK_IDX_W'(i_word.lock_id);
        dec_sh.thread_id = THR_IDX_W'(i_word.thread_id);
        dec_sh.address   = i_word.address;
        dec_sh.wr_access = i_word.wr_access;
        unique case (i_word.action)
            ACT_START: begin
                dec_rej = ids_full;
                dec_vc.go       = !ids_full;
                dec_vc.op       = VC_ZERO;
                dec_vc.dst_row  = THR_IDX_W'(r_next);
                dec_vc.tick_en  = 1'b1;
                dec_vc.tick_idx = THR_IDX_W'(r_next);
                dec_bump = !ids_full;
            end
            ACT_FORK: begin
                dec_rej = ids_full || !alloc_t;
                dec_vc.go        = !dec_rej;
                dec_vc.op        = VC_COPY;
                dec_vc.src_row   = THR_IDX_W'(i_word.thread_id);
                dec_vc.dst_row   = THR_IDX_W'(r_next);
                dec_vc.tick_en   = 1'b1;
                dec_vc.tick_idx  = THR_IDX_W'(r_next);
                dec_vc.post_tick = 1'b1;
                dec_vc.post_row  = THR_IDX_W'(i_word.thread_id);
                dec_bump = !dec_rej;
            end
            ACT_JOIN: begin
                dec_rej = !alloc_t || !alloc_o;
                dec_vc.go      = !dec_rej;
                dec_vc.op      = VC_MAX;
                dec_vc.src_row = THR_IDX_W'(i_word.other_thread_id);
                dec_vc.dst_row = THR_IDX_W'(i_word.thread_id);
            end
            ACT_ACQUIRE: begin
                dec_rej = !alloc_t || !lock_ok;
                dec_vc.go       = !dec_rej;
                dec_vc.op       = VC_MAX;
                dec_vc.src_lock = 1'b1;
                dec_vc.dst_row  = THR_IDX_W'(i_word.thread_id);
            end
            ACT_RELEASE: begin
                dec_rej = !alloc_t || !lock_ok;
                dec_vc.go        = !dec_rej;
                dec_vc.op        = VC_MAX;
                dec_vc.dst_lock  = 1'b1;
                dec_vc.src_row   = THR_IDX_W'(i_word.thread_id);
                dec_vc.post_tick = 1'b1;
                dec_vc.post_row  = THR_IDX_W'(i_word.thread_id);
            end
            ACT_ACCESS: begin
                dec_rej = !alloc_t;
                dec_sh.go = alloc_t;
            end
            default: begin
                dec_rej = 1'b1;
            end
        endcase
    end

    // Accept words, dispatch them and return one result word each
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= T_IDLE;
            r_next   <= '0;
            r_vc_cmd <= '0;
            r_sh_cmd <= '0;
            o_done   <= 1'b0;
        end else begin
            unique case (r_state)
                T_IDLE: begin
                    o_done <= accept && dec_rej;
                    if (accept) begin
                        if (dec_rej) begin
                            o_word <= '{race: 1'b0, new_thread_id: NONE_ID,
                                        table_full: 1'b0, rejected: 1'b1};
                        end else if (dec_vc.go) begin
                            r_vc_cmd <= dec_vc;
                            r_newid  <= dec_bump ? 4'(r_next) : NONE_ID;
                            if (dec_bump) begin
                                r_next <= r_next + 1'b1;
                            end
                            r_state <= T_VC;
                        end else begin
                            r_sh_cmd <= dec_sh;
                            r_state  <= T_SH;
                        end
                    end
                end
                T_VC: begin
                    r_vc_cmd.go <= 1'b0;
                    o_done      <= vc_stat.done;
                    if (vc_stat.done) begin
                        o_word  <= '{race: 1'b0, new_thread_id: r_newid,
                                     table_full: 1'b0, rejected: 1'b0};
                        r_state <= T_IDLE;
                    end
                end
                T_SH: begin
                    r_sh_cmd.go <= 1'b0;
                    o_done      <= sh_stat.done;
                    if (sh_stat.done) begin
                        o_word  <= '{race: sh_stat.race, new_thread_id: NONE_ID,
                                     table_full: sh_stat.full, rejected: 1'b0};
                        r_state <= T_IDLE;
                    end
                end
                default: begin
                    o_done  <= 1'b0;
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

    vcrd_vc_unit #(
        .THREADS    (THREADS),
        .LOCKS      (LOCKS),
        .EPOCH_BITS (EPOCH_BITS)
    ) u_vc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (r_vc_cmd),
        .i_look       (look),
        .o_look_epoch (look_epoch),
        .o_stat       (vc_stat)
    );

    vcrd_shadow_unit #(
        .THREADS    (THREADS),
        .CELLS      (CELLS),
        .BUCKETS    (BUCKETS),
        .EPOCH_BITS (EPOCH_BITS)
    ) u_shadow (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (r_sh_cmd),
        .i_look_epoch (look_epoch),
        .o_look       (look),
        .o_stat       (sh_stat)
    );

    // Check dispatch and result consistency
    `VCRD_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, accept, busy || o_done, "accepted word stalled")
    `VCRD_ASSERT_IMP(a_vc_done_owned, i_clk, i_rst_n, vc_stat.done, r_state == T_VC, "stray clock walk done")
    `VCRD_ASSERT_IMP(a_full_quiet, i_clk, i_rst_n, o_done && o_word.table_full, !o_word.race && !o_word.rejected, "full table result carries other flags")
    `VCRD_ASSERT_IMP(a_newid_clean, i_clk, i_rst_n, o_done && (o_word.new_thread_id != NONE_ID), !o_word.rejected && !o_word.race && !o_word.table_full, "new id with error flags")

endmodule

[rtl/core/vcrd_vc_unit.sv]
module vcrd_vc_unit import vcrd_pkg::*; #(
    parameter int THREADS    = 8,
    parameter int LOCKS      = 16,
    parameter int EPOCH_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_vc_cmd               i_cmd,
    input  t_vc_look              i_look,
    output logic [EPOCH_BITS-1:0] o_look_epoch,
    output t_vc_stat              o_stat
);

    localparam int TW  = $clog2(THREADS);
    localparam int LW  = (LOCKS > 1) ? $clog2(LOCKS) : 1;
    localparam int TAW = 2 * TW;
    localparam int LAW = LW + TW;
    localparam logic [EPOCH_BITS-1:0] EPOCH_MAX = '1;
    localparam logic [TW-1:0] LAST_IDX = TW'(THREADS - 1);

    typedef enum logic [2:0] {
        V_CLEAR,
        V_IDLE,
        V_WALK,
        V_TICK_RD,
        V_TICK_WR
    } t_state;

    function automatic logic [EPOCH_BITS-1:0] sat_inc(input logic [EPOCH_BITS-1:0] v);
        sat_inc = (v == EPOCH_MAX) ? v : v + 1'b1;
    endfunction

    logic [EPOCH_BITS-1:0] thr_mem [1 << TAW];
    logic [EPOCH_BITS-1:0] lock_mem [1 << LAW];
    logic [EPOCH_BITS-1:0] r_thr_a;
    logic [EPOCH_BITS-1:0] r_thr_b;
    logic [EPOCH_BITS-1:0] r_lock_q;

    t_state        r_state;
    t_vc_cmd       r_cmd;
    logic [LAW-1:0] r_clr;
    logic          r_issue;
    logic [TW-1:0] r_idx;
    logic          r_rv;
    logic [TW-1:0] r_ridx;
    logic          r_done;

    logic [TW-1:0] src_row;
    logic [TW-1:0] dst_row;
    logic [TW-1:0] post_row;
    logic [LW-1:0] lock_row;

    logic [TAW-1:0] thr_a_addr;
    logic [TAW-1:0] thr_b_addr;
    logic [LAW-1:0] lock_addr;

    logic [EPOCH_BITS-1:0] src_val;
    logic [EPOCH_BITS-1:0] dst_val;
    logic [EPOCH_BITS-1:0] op_val;
    logic [EPOCH_BITS-1:0] walk_val;

    logic                  thr_we;
    logic [TAW-1:0]        thr_wa;
    logic [EPOCH_BITS-1:0] thr_wd;
    logic                  lock_we;
    logic [LAW-1:0]        lock_wa;
    logic [EPOCH_BITS-1:0] lock_wd;

    assign src_row  = TW'(r_cmd.src_row);
    assign dst_row  = TW'(r_cmd.dst_row);
    assign post_row = TW'(r_cmd.post_row);
    assign lock_row = LW'(r_cmd.lock_row);

    // Pick read addresses: walk rows, the tick entry, or an outside lookup
    always_comb begin
        unique case (r_state)
            V_WALK:              thr_a_addr = {src_row, r_idx};
            V_TICK_RD, V_TICK_WR: thr_a_addr = {post_row, post_row};
            default:             thr_a_addr = {TW'(i_look.row), TW'(i_look.col)};
        endcase
    end
    assign thr_b_addr = {dst_row, r_idx};
    assign lock_addr  = {lock_row, r_idx};

    // Combine one element of the walk
    assign src_val = r_cmd.src_lock ? r_lock_q : r_thr_a;
    assign dst_val = r_cmd.dst_lock ? r_lock_q : r_thr_b;

    always_comb begin
        unique case (r_cmd.op)
            VC_ZERO: op_val = '0;
            VC_COPY: op_val = src_val;
            VC_MAX:  op_val = (src_val > dst_val) ? src_val : dst_val;
            default: op_val = dst_val;
        endcase
        if (r_cmd.tick_en && (r_ridx == TW'(r_cmd.tick_idx))) begin
            walk_val = sat_inc(op_val);
        end else begin
            walk_val = op_val;
        end
    end

    // Steer write ports
    always_comb begin
        thr_we  = 1'b0;
        thr_wa  = {dst_row, r_ridx};
        thr_wd  = walk_val;
        lock_we = 1'b0;
        lock_wa = {lock_row, r_ridx};
        lock_wd = walk_val;
        unique case (r_state)
            V_CLEAR: begin
                lock_we = 1'b1;
                lock_wa = r_clr;
                lock_wd = '0;
            end
            V_WALK: begin
                lock_we = r_rv && r_cmd.dst_lock;
                thr_we  = r_rv && !r_cmd.dst_lock;
            end
            V_TICK_WR: begin
                thr_we = 1'b1;
                thr_wa = {post_row, post_row};
                thr_wd = sat_inc(r_thr_a);
            end
            default: begin
                thr_we  = 1'b0;
                lock_we = 1'b0;
            end
        endcase
    end

    // Thread clock memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (thr_we) begin
            thr_mem[thr_wa] <= thr_wd;
        end
        r_thr_a <= thr_mem[thr_a_addr];
        r_thr_b <= thr_mem[thr_b_addr];
    end

    // Lock clock memory
    always_ff @(posedge i_clk) begin
        if (lock_we) begin
            lock_mem[lock_wa] <= lock_wd;
        end
        r_lock_q <= lock_mem[lock_addr];
    end

    // Sequence the clear pass, element walk and trailing tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= V_CLEAR;
            r_clr   <= '0;
            r_issue <= 1'b0;
            r_rv    <= 1'b0;
            r_idx   <= '0;
            r_ridx  <= '0;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                V_CLEAR: begin
                    r_done <= 1'b0;
                    r_clr  <= r_clr + 1'b1;
                    if (r_clr == '1) begin
                        r_state <= V_IDLE;
                    end
                end
                V_IDLE: begin
                    r_done <= 1'b0;
                    if (i_cmd.go) begin
                        r_cmd   <= i_cmd;
                        r_idx   <= '0;
                        r_issue <= 1'b1;
                        r_rv    <= 1'b0;
                        r_state <= V_WALK;
                    end
                end
                V_WALK: begin
                    r_rv   <= r_issue;
                    r_ridx <= r_idx;
                    r_done <= r_rv && (r_ridx == LAST_IDX) && !r_cmd.post_tick;
                    if (r_issue) begin
                        if (r_idx == LAST_IDX) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                    if (r_rv && (r_ridx == LAST_IDX)) begin
                        if (r_cmd.post_tick) begin
                            r_state <= V_TICK_RD;
                        end else begin
                            r_state <= V_IDLE;
                        end
                    end
                end
                V_TICK_RD: begin
                    r_done  <= 1'b0;
                    r_state <= V_TICK_WR;
                end
                V_TICK_WR: begin
                    r_done  <= 1'b1;
                    r_state <= V_IDLE;
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= V_IDLE;
                end
            endcase
        end
    end

    assign o_look_epoch = r_thr_a;
    assign o_stat.ready = (r_state != V_CLEAR);
    assign o_stat.done  = r_done;

endmodule

[rtl/core/vcrd_shadow_unit.sv]
module vcrd_shadow_unit import vcrd_pkg::*; #(
    parameter int THREADS    = 8,
    parameter int CELLS      = 4,
    parameter int BUCKETS    = 1024,
    parameter int EPOCH_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_sh_cmd               i_cmd,
    input  logic [EPOCH_BITS-1:0] i_look_epoch,
    output t_vc_look              o_look,
    output t_sh_stat              o_stat
);

    localparam int TW = $clog2(THREADS);
    localparam int HB = $clog2(BUCKETS);
    localparam int CI = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam logic [CI-1:0] LAST_CELL = CI'(CELLS - 1);

    typedef struct packed {
        logic                  valid;
        logic [TW-1:0]         tid;
        logic                  wr;
        logic [EPOCH_BITS-1:0] epoch;
    } t_cell;

    typedef t_cell [CELLS-1:0] t_row;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE_RD,
        S_PROBE_CK,
        S_OWN,
        S_SCAN,
        S_WRITE
    } t_state;

    logic [KEY_W-1:0] key_mem [BUCKETS];
    t_row             cell_mem [BUCKETS];
    logic [KEY_W-1:0] r_key_q;
    t_row             r_row_q;

    t_state                 r_state;
    logic [HB-1:0]          r_clr;
    logic [TW-1:0]          r_tid;
    logic                   r_wr;
    logic [WORD_ADDR_W-1:0] r_word;
    logic [HB-1:0]          r_bkt;
    logic [HB-1:0]          r_probe;
    t_row                   r_row;
    logic [CI-1:0]          r_ci;
    logic                   r_issue;
    logic                   r_cv;
    logic [CI-1:0]          r_cci;
    logic                   r_first;
    logic [EPOCH_BITS-1:0]  r_cur;
    logic                   r_race;
    logic                   r_full;
    logic                   r_done;

    logic [KEY_W-1:0] key;
    logic [2*HB-1:0]  hash_prod;
    logic             key_hit;
    logic             key_empty;
    t_cell            chk_cell;
    logic             conflict;

    logic             own_hit;
    logic             free_hit;
    logic [CI-1:0]    own_idx;
    logic [CI-1:0]    free_idx;
    logic [CI-1:0]    slot;
    t_cell            old_cell;
    t_row             new_row;

    logic             key_we;
    logic [HB-1:0]    key_wa;
    logic [KEY_W-1:0] key_wd;
    logic             cell_we;
    logic [HB-1:0]    cell_wa;
    t_row             cell_wd;

    // Key is the word index plus one so that zero marks an empty bucket
    assign key       = KEY_W'(r_word) + KEY_W'(1);
    assign hash_prod = (2*HB)'(r_word[HB-1:0]) * (2*HB)'(HASH_MUL[HB-1:0]);
    assign key_hit   = (r_key_q == key);
    assign key_empty = (r_key_q == '0);

    // Look up the accessor's clock at its own entry, then at each cell's thread
    assign o_look.row = THR_IDX_W'(r_tid);
    assign o_look.col = (r_state == S_OWN) ? THR_IDX_W'(r_tid) : THR_IDX_W'(r_row[r_ci].tid);

    // Flag an unordered conflict with one recorded cell
    assign chk_cell = r_row[r_cci];
    assign conflict = chk_cell.valid && (chk_cell.tid != r_tid)
                      && (chk_cell.wr || r_wr) && (chk_cell.epoch > i_look_epoch);

    // Choose the cell to record into: own cell, else first free, else cell 0
    always_comb begin
        own_hit  = 1'b0;
        free_hit = 1'b0;
        own_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < CELLS; i++) begin
            if (!own_hit && r_row[i].valid && (r_row[i].tid == r_tid)) begin
                own_hit = 1'b1;
                own_idx = CI'(i);
            end
            if (!free_hit && !r_row[i].valid) begin
                free_hit = 1'b1;
                free_idx = CI'(i);
            end
        end
        slot = own_hit ? own_idx : (free_hit ? free_idx : '0);
        old_cell = r_row[slot];
        new_row  = r_row;
        new_row[slot].valid = 1'b1;
        new_row[slot].tid   = r_tid;
        new_row[slot].epoch = r_cur;
        new_row[slot].wr    = r_wr || (old_cell.valid && (old_cell.tid == r_tid)
                              && (old_cell.epoch == r_cur) && old_cell.wr);
    end

    // Steer write ports
    always_comb begin
        key_we  = 1'b0;
        key_wa  = r_bkt;
        key_wd  = key;
        cell_we = 1'b0;
        cell_wa = r_bkt;
        cell_wd = new_row;
        unique case (r_state)
            S_CLEAR: begin
                key_we  = 1'b1;
                key_wa  = r_clr;
                key_wd  = '0;
                cell_we = 1'b1;
                cell_wa = r_clr;
                cell_wd = '0;
            end
            S_PROBE_CK: begin
                key_we = !key_hit && key_empty;
            end
            S_WRITE: begin
                cell_we = 1'b1;
            end
            default: begin
                key_we  = 1'b0;
                cell_we = 1'b0;
            end
        endcase
    end

    // Key memory
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[key_wa] <= key_wd;
        end
        r_key_q <= key_mem[r_bkt];
    end

    // Cell memory, one bucket row per entry
    always_ff @(posedge i_clk) begin
        if (cell_we) begin
            cell_mem[cell_wa] <= cell_wd;
        end
        r_row_q <= cell_mem[r_bkt];
    end

    // Sequence clear, hash, probe, scan and record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_issue <= 1'b0;
            r_cv    <= 1'b0;
            r_first <= 1'b0;
            r_race  <= 1'b0;
            r_full  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_done <= 1'b0;
                    r_clr  <= r_clr + 1'b1;
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_done <= 1'b0;
                    if (i_cmd.go) begin
                        r_tid   <= TW'(i_cmd.thread_id);
                        r_wr    <= i_cmd.wr_access;
                        r_word  <= i_cmd.address[ADDR_W-1:3];
                        r_race  <= 1'b0;
                        r_full  <= 1'b0;
                        r_probe <= '0;
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    r_done  <= 1'b0;
                    r_bkt   <= hash_prod[HB-1:0];
                    r_state <= S_PROBE_RD;
                end
                S_PROBE_RD: begin
                    r_done  <= 1'b0;
                    r_state <= S_PROBE_CK;
                end
                S_PROBE_CK: begin
                    r_done <= !(key_hit || key_empty) && (r_probe == '1);
                    if (key_hit || key_empty) begin
                        r_row   <= r_row_q;
                        r_state <= S_OWN;
                    end else if (r_probe == '1) begin
                        r_full  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_bkt   <= r_bkt + 1'b1;
                        r_probe <= r_probe + 1'b1;
                        r_state <= S_PROBE_RD;
                    end
                end
                S_OWN: begin
                    r_done  <= 1'b0;
                    r_ci    <= '0;
                    r_issue <= 1'b1;
                    r_cv    <= 1'b0;
                    r_first <= 1'b1;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_done  <= 1'b0;
                    r_first <= 1'b0;
                    if (r_first) begin
                        r_cur <= i_look_epoch;
                    end
                    r_cv  <= r_issue;
                    r_cci <= r_ci;
                    if (r_issue) begin
                        if (r_ci == LAST_CELL) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_ci <= r_ci + 1'b1;
                        end
                    end
                    if (r_cv) begin
                        if (conflict) begin
                            r_race <= 1'b1;
                        end
                        if (r_cci == LAST_CELL) begin
                            r_state <= S_WRITE;
                        end
                    end
                end
                S_WRITE: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stat.ready = (r_state != S_CLEAR);
    assign o_stat.done  = r_done;
    assign o_stat.race  = r_race;
    assign o_stat.full  = r_full;

endmodule
